>>> rtl/core/olist_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ordered list unit
package olist_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int KIND_W     = 3;
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = CAPACITY / GROUP_SIZE;
    localparam int GRP_IDX_W  = $clog2(GROUP_SIZE);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_SEARCH = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic             rd_en;
        logic             srch_en;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        word_t            val;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 hit;
        logic [GRP_IDX_W-1:0] first;
        word_t                data;
    } grp_t;

endpackage

>>> rtl/core/olist_cell.sv
`timescale 1ns / 1ps
// one list cell: holds an entry, shifts with its neighbours, compares and selects
module olist_cell
    import olist_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] idx,
    input  word_t            left_data,
    input  word_t            right_data,
    output word_t            data,
    output logic             hit,
    output word_t            rd_data
);

    word_t            data_reg;
    word_t            data_next;
    logic             hit_reg;
    logic             hit_next;
    word_t            rd_reg;
    word_t            rd_next;
    logic [CNT_W-1:0] idx_ext;

    assign idx_ext = CNT_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (idx_ext == ctrl.pos)
            begin
                data_next = ctrl.val;
            end
            else if (idx_ext > ctrl.pos)
            begin
                data_next = left_data;
            end
        end
        else if (ctrl.del_en && (idx_ext >= ctrl.pos))
        begin
            data_next = right_data;
        end
    end

    always_comb
    begin
        hit_next = ctrl.srch_en && (idx_ext < ctrl.cnt) && (data_reg == ctrl.val);
        rd_next  = (ctrl.rd_en && (idx_ext == ctrl.pos)) ? data_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
        rd_reg   <= rd_next;
    end

    assign data    = data_reg;
    assign hit     = hit_reg;
    assign rd_data = rd_reg;

endmodule

>>> rtl/core/olist_group.sv
`timescale 1ns / 1ps
// registered reduction over one group of cells: first hit and read data
module olist_group
    import olist_pkg::*;
(
    input  logic                                clk,
    input  logic [GROUP_SIZE-1:0]               hit,
    input  logic [GROUP_SIZE-1:0][WORD_W-1:0]   rd,
    output grp_t                                grp
);

    grp_t grp_reg;
    grp_t grp_next;

    always_comb
    begin
        grp_next = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                grp_next.hit   = 1'b1;
                grp_next.first = GRP_IDX_W'(i);
            end
            grp_next.data = grp_next.data | rd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign grp = grp_reg;

endmodule

>>> rtl/core/ordered_list_insert_delete_search_unit.sv
`timescale 1ns / 1ps
// top level of the ordered list unit: control, cell row and result reduction
// the result strobe follows the exec, reduce and final states of an accepted item
// a new item is accepted only back in idle, after the cell update, group reduce and final select
// each item is applied to the row of 64 cells in the exec state; search and read reduce over two stages
// reset clears the count and control; list entries are undefined until written
// results are strobed for one cycle and cannot be stalled
module ordered_list_insert_delete_search_unit
    import olist_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] kind,
    input  logic [CNT_W-1:0]  position,
    input  logic signed [WORD_W-1:0] value,
    output logic              done,
    output logic [1:0]        status,
    output logic [IDX_W-1:0]  found_position,
    output logic signed [WORD_W-1:0] read_value,
    output logic [CNT_W-1:0]  count
);

    state_t           state_reg;
    state_t           state_next;
    logic [KIND_W-1:0] kind_reg;
    logic [CNT_W-1:0] pos_reg;
    word_t            val_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          stat_reg;
    status_t          stat_next;
    logic             done_reg;
    logic             done_next;
    status_t          out_stat_reg;
    logic [IDX_W-1:0] out_found_reg;
    word_t            out_rd_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic             accept;
    logic             in_exec;
    logic             in_final;
    logic             full;
    logic             ins_ok;
    logic             del_ok;
    logic             rd_ok;
    cell_ctrl_t       ctrl;

    logic [CAPACITY-1:0][WORD_W-1:0] data_w;
    logic [CAPACITY-1:0][WORD_W-1:0] left_w;
    logic [CAPACITY-1:0][WORD_W-1:0] right_w;
    logic [CAPACITY-1:0][WORD_W-1:0] rd_w;
    logic [CAPACITY-1:0]             hit_w;
    grp_t                            grp_w [NUM_GROUPS];

    logic             any_hit;
    logic [IDX_W-1:0] found_idx;
    word_t            rd_sum;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:   state_next = S_REDUCE;
            S_REDUCE: state_next = S_FINAL;
            S_FINAL:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy     = 1'b1;
        in_exec  = 1'b0;
        in_final = 1'b0;
        unique case (state_reg)
            S_IDLE:   busy = 1'b0;
            S_EXEC:   in_exec = 1'b1;
            S_REDUCE: ;
            S_FINAL:  in_final = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    assign accept = start && !busy;

    // operation checks
    always_comb
    begin
        full   = (count_reg >= CNT_W'(CAPACITY));
        ins_ok = (kind_reg == KIND_INSERT) && !full && (pos_reg <= count_reg);
        del_ok = (kind_reg == KIND_DELETE) && (pos_reg < count_reg);
        rd_ok  = (kind_reg == KIND_READ) && (pos_reg < count_reg);

        stat_next  = ST_OK;
        count_next = count_reg;
        unique case (kind_reg)
            KIND_CLEAR:
            begin
                count_next = '0;
            end
            KIND_READ:
            begin
                stat_next = rd_ok ? ST_OK : ST_BADPOS;
            end
            KIND_INSERT:
            begin
                if (full)
                begin
                    stat_next = ST_FULL;
                end
                else if (!ins_ok)
                begin
                    stat_next = ST_BADPOS;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_DELETE:
            begin
                if (del_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    stat_next = ST_BADPOS;
                end
            end
            KIND_SEARCH:
            begin
                stat_next = ST_NOTFOUND;
            end
            default:
            begin
                stat_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        ctrl.ins_en  = in_exec && ins_ok;
        ctrl.del_en  = in_exec && del_ok;
        ctrl.rd_en   = in_exec && rd_ok;
        ctrl.srch_en = in_exec && (kind_reg == KIND_SEARCH);
        ctrl.pos     = pos_reg;
        ctrl.cnt     = count_reg;
        ctrl.val     = val_reg;
    end

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_w[gi] = '0;
            end
            else
            begin : g_mid_l
                assign left_w[gi] = data_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w[gi] = '0;
            end
            else
            begin : g_mid_r
                assign right_w[gi] = data_w[gi+1];
            end

            olist_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (IDX_W'(gi)),
                .left_data  (left_w[gi]),
                .right_data (right_w[gi]),
                .data       (data_w[gi]),
                .hit        (hit_w[gi]),
                .rd_data    (rd_w[gi])
            );
        end

        for (gi = 0; gi < NUM_GROUPS; gi++)
        begin : g_grp
            olist_group u_group
            (
                .clk (clk),
                .hit (hit_w[gi*GROUP_SIZE +: GROUP_SIZE]),
                .rd  (rd_w[gi*GROUP_SIZE +: GROUP_SIZE]),
                .grp (grp_w[gi])
            );
        end
    endgenerate

    // final select over groups
    always_comb
    begin
        any_hit   = 1'b0;
        found_idx = '0;
        rd_sum    = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_w[g].hit)
            begin
                any_hit   = 1'b1;
                found_idx = (IDX_W'(g) << GRP_IDX_W) | IDX_W'(grp_w[g].first);
            end
            rd_sum = rd_sum | grp_w[g].data;
        end
    end

    assign done_next = in_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (in_exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            pos_reg  <= position;
            val_reg  <= value;
        end
        if (in_exec)
        begin
            stat_reg <= stat_next;
        end
        if (in_final)
        begin
            out_count_reg <= count_reg;
            out_rd_reg    <= rd_sum;
            if ((kind_reg == KIND_SEARCH) && any_hit)
            begin
                out_stat_reg  <= ST_OK;
                out_found_reg <= found_idx;
            end
            else
            begin
                out_stat_reg  <= stat_reg;
                out_found_reg <= '0;
            end
        end
    end

    assign done           = done_reg;
    assign status         = out_stat_reg;
    assign found_position = out_found_reg;
    assign read_value     = out_rd_reg;
    assign count          = out_count_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_final |=> done)
        else $error("missing result strobe");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (found_position != '0)) |-> (status == ST_OK))
        else $error("found position with failing status");

endmodule
